// ----- sv/ert_pkg.sv -----
package ert_pkg;

	// Fixed field widths
	localparam int CNT_W      = 6;   // step_count, pulse_count, start_offset
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int CHAN_W     = 5;
	localparam int IDX_W      = 5;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam int OUT_W      = NOTE_W + VEL_W + CHAN_W + IDX_W;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_STEP_COUNT   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PULSE_COUNT  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_START_OFFSET = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_NOTE_NUMBER  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_VELOCITY_OVR = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_MIDI_CHANNEL = 3'd5;

	localparam logic [VEL_W-1:0]  VEL_DEFAULT   = 7'd100;
	localparam logic [NOTE_W-1:0] NOTE_RESET    = 7'd36;
	localparam logic [CHAN_W-1:0] CHAN_MIN      = 5'd1;
	localparam logic [CHAN_W-1:0] CHAN_MAX      = 5'd16;
	localparam logic [CNT_W-1:0]  STEPS_MIN     = 6'd2;
	localparam logic [CNT_W-1:0]  STEPS_RESET   = 6'd16;
	localparam logic [CNT_W-1:0]  PULSES_RESET  = 6'd4;
	localparam logic [CNT_W-1:0]  START_MIN     = 6'd1;

	typedef struct packed {
		logic [CNT_W-1:0]  steps;
		logic [CNT_W-1:0]  pulses;
		logic [CNT_W-1:0]  start;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel_ovr;
		logic [CHAN_W-1:0] chan;
		logic              stale;
	} cfg_t;

	typedef struct packed {
		logic load;        // latch the accepted item, arm the walk and the divider
		logic build_step;  // one bucket step of the pattern walk
		logic div_step;    // one remainder bit
		logic commit;      // evaluate the step, update history, load the output
	} cmd_t;

	typedef struct packed {
		logic stale;
		logic build_last;
		logic div_last;
		logic fire;
		logic out_busy;
	} sts_t;

endpackage

// ----- sv/ert_cfg.sv -----
module ert_cfg import ert_pkg::*; #(
	parameter int MAX_STEPS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  clear_stale,
	output cfg_t                  cfg
);

	localparam logic [CNT_W:0] MAXS = (CNT_W+1)'(MAX_STEPS);
	localparam logic [CNT_W-1:0] RST_STEPS =
		(MAX_STEPS < 16) ? CNT_W'(MAX_STEPS) : STEPS_RESET;
	localparam logic [CNT_W-1:0] RST_PULSES =
		(RST_STEPS < PULSES_RESET) ? RST_STEPS : PULSES_RESET;

	cfg_t            cfg_q;
	logic [CNT_W-1:0] wv;
	logic [CNT_W-1:0] new_steps;
	logic [CNT_W-1:0] new_start;
	logic [CHAN_W-1:0] cv;

	assign wv = cfg_wdata[CNT_W-1:0];
	assign cv = cfg_wdata[CHAN_W-1:0];

	always_comb begin
		if (wv < STEPS_MIN)
			new_steps = STEPS_MIN;
		else if ({1'b0, wv} > MAXS)
			new_steps = MAXS[CNT_W-1:0];
		else
			new_steps = wv;
		if (wv > cfg_q.steps)
			new_start = cfg_q.steps;
		else if (wv < START_MIN)
			new_start = START_MIN;
		else
			new_start = wv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps   <= RST_STEPS;
			cfg_q.pulses  <= RST_PULSES;
			cfg_q.start   <= START_MIN;
			cfg_q.note    <= NOTE_RESET;
			cfg_q.vel_ovr <= '0;
			cfg_q.chan    <= CHAN_MIN;
			cfg_q.stale   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_STEP_COUNT: begin
					cfg_q.steps <= new_steps;
					if (cfg_q.pulses > new_steps)
						cfg_q.pulses <= new_steps;
					if (cfg_q.start > new_steps)
						cfg_q.start <= new_steps;
					cfg_q.stale <= 1'b1;
				end
				REG_PULSE_COUNT: begin
					cfg_q.pulses <= (wv > cfg_q.steps) ? cfg_q.steps : wv;
					cfg_q.stale  <= 1'b1;
				end
				REG_START_OFFSET: begin
					cfg_q.start <= new_start;
					cfg_q.stale <= 1'b1;
				end
				REG_NOTE_NUMBER:  cfg_q.note    <= cfg_wdata[NOTE_W-1:0];
				REG_VELOCITY_OVR: cfg_q.vel_ovr <= cfg_wdata[VEL_W-1:0];
				REG_MIDI_CHANNEL: begin
					if (cv < CHAN_MIN)
						cfg_q.chan <= CHAN_MIN;
					else if (cv > CHAN_MAX)
						cfg_q.chan <= CHAN_MAX;
					else
						cfg_q.chan <= cv;
				end
				default: ;
			endcase
		end else if (clear_stale) begin
			cfg_q.stale <= 1'b0;
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/ert_dp.sv -----
module ert_dp import ert_pkg::*; #(
	parameter int MAX_STEPS     = 32,
	parameter int POSITION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  cmd_t                     cmd,
	input  logic [POSITION_BITS-1:0] position,
	input  logic                     restart,
	input  logic                     m_tready,
	output sts_t                     sts,
	output logic                     m_tvalid,
	output logic [OUT_W-1:0]         m_tdata
);

	localparam int STEP_W = $clog2(MAX_STEPS);
	localparam int DCNT_W = $clog2(POSITION_BITS);

	// Pattern walk
	logic [MAX_STEPS-1:0] pattern_q;
	logic [CNT_W:0]       bucket_q;
	logic [CNT_W-1:0]     bidx_q;
	logic [STEP_W-1:0]    wp_q;
	logic [CNT_W:0]       bsum;
	logic                 bhit;
	logic [CNT_W:0]       wp_inc;
	logic                 wp_wrap;

	// Remainder unit
	logic [POSITION_BITS-1:0] pos_sh_q;
	logic [CNT_W-1:0]         rem_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [CNT_W:0]           trial;
	logic [CNT_W:0]           trial_sub;

	// Step history and output
	logic              restart_q;
	logic              last_valid_q;
	logic [STEP_W-1:0] last_q;
	logic [STEP_W-1:0] step;
	logic              change;
	logic              fire;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic [VEL_W-1:0]  vel;

	assign bsum    = bucket_q + {1'b0, cfg.pulses};
	assign bhit    = bsum >= {1'b0, cfg.steps};
	assign wp_inc  = (CNT_W+1)'(wp_q) + 1'b1;
	assign wp_wrap = wp_inc == {1'b0, cfg.steps};

	assign trial     = {rem_q, pos_sh_q[POSITION_BITS-1]};
	assign trial_sub = trial - {1'b0, cfg.steps};

	assign step   = rem_q[STEP_W-1:0];
	assign change = !(last_valid_q && !restart_q) || (step != last_q);
	assign fire   = change && pattern_q[step];
	assign vel    = (cfg.vel_ovr != '0) ? cfg.vel_ovr : VEL_DEFAULT;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_sh_q  <= position;
			rem_q     <= '0;
			dcnt_q    <= '0;
			restart_q <= restart;
			if (cfg.stale) begin
				pattern_q <= '0;
				bucket_q  <= {1'b0, cfg.steps} - {1'b0, cfg.pulses};
				bidx_q    <= '0;
				wp_q      <= STEP_W'(cfg.start - START_MIN);
			end
		end
		if (cmd.build_step) begin
			bucket_q <= bhit ? (bsum - {1'b0, cfg.steps}) : bsum;
			// no pulses: the walk would still carry, keep rests
			if (bhit && cfg.pulses != '0)
				pattern_q[wp_q] <= 1'b1;
			bidx_q <= bidx_q + 1'b1;
			wp_q   <= wp_wrap ? '0 : wp_inc[STEP_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q    <= trial_sub[CNT_W] ? trial[CNT_W-1:0] : trial_sub[CNT_W-1:0];
			pos_sh_q <= {pos_sh_q[POSITION_BITS-2:0], 1'b0};
			dcnt_q   <= dcnt_q + 1'b1;
		end
		if (cmd.commit && change)
			last_q <= step;
		if (cmd.commit && fire)
			out_data_q <= {IDX_W'(step), cfg.chan, vel, cfg.note};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit && change)
				last_valid_q <= 1'b1;
			if (cmd.commit && fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.stale      = cfg.stale;
	assign sts.build_last = bidx_q == (cfg.steps - 1'b1);
	assign sts.div_last   = dcnt_q == DCNT_W'(POSITION_BITS - 1);
	assign sts.fire       = fire;
	assign sts.out_busy   = out_valid_q && !m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- sv/ert_ctrl.sv -----
module ert_ctrl import ert_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  sts_t sts,
	output logic s_tready,
	output cmd_t cmd,
	output logic clear_stale
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_BUILD  = 4'b0010,
		ST_DIV    = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		clear_stale    = 1'b0;
		s_tready       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sts.stale ? ST_BUILD : ST_DIV;
				end
			end
			ST_BUILD: begin
				cmd.build_step = 1'b1;
				if (sts.build_last) begin
					clear_stale = 1'b1;
					state_d     = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				// hold while a hit waits for the output slot
				if (!(sts.fire && sts.out_busy)) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- sv/euclidean_rhythm_trigger_top.sv -----
// One channel of a Euclidean rhythm sequencer. Each input transfer carries an
// absolute sixteenth-note position and a restart flag; the block reduces the
// position modulo the step count and sends one note-on transfer when the step
// differs from the last one seen, or restart is set or no step was seen yet,
// and the pattern has a hit there. The pattern is rebuilt by a Bresenham bucket
// walk, rotated by start_offset - 1, on the first item after any write to
// step_count, pulse_count or start_offset. An accepted item goes through the
// restoring divider, one remainder bit per cycle, then the decide state; only
// then is the block ready again. The first item after a pattern change first
// walks the bucket over step_count steps, one pattern bit per cycle.
// The next item is taken while a note-on still waits in the output register;
// the block holds in the decide cycle only when a new hit meets a full output
// register. Configuration writes take effect at once and must only be issued
// while the block is idle; out-of-range values saturate.
module euclidean_rhythm_trigger_top import ert_pkg::*; #(
	parameter int MAX_STEPS     = 32,
	parameter int POSITION_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [CFG_DATA_W-1:0]         cfg_wdata,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [((POSITION_BITS+7)/8)*8-1:0] s_tdata,  // step_position, zero pad
	input  logic                          s_tuser,  // restart
	// note-on stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [OUT_W-1:0]              m_tdata   // note, velocity, midi_channel, step_index
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic clear_stale;

	// Configuration registers with saturation and the stale mark
	ert_cfg #(
		.MAX_STEPS(MAX_STEPS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.clear_stale(clear_stale),
		.cfg        (cfg)
	);

	// Sequencer: accept, walk the pattern if stale, divide, decide
	ert_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.sts        (sts),
		.s_tready   (s_tready),
		.cmd        (cmd),
		.clear_stale(clear_stale)
	);

	// Pattern register, remainder unit, step history and output register
	ert_dp #(
		.MAX_STEPS    (MAX_STEPS),
		.POSITION_BITS(POSITION_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.position(s_tdata[POSITION_BITS-1:0]),
		.restart (s_tuser),
		.m_tready(m_tready),
		.sts     (sts),
		.m_tvalid(m_tvalid),
		.m_tdata (m_tdata)
	);

endmodule

// ----- sv/ert_checker.sv -----
module ert_checker import ert_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	localparam int VEL_LO  = NOTE_W;
	localparam int CHAN_LO = NOTE_W + VEL_W;

	// a stalled note-on holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("note-on dropped or changed while stalled");

	// one item at a time: ready drops after each transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[VEL_LO +: VEL_W] != '0)
		else $error("note-on with zero velocity");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CHAN_LO +: CHAN_W] >= CHAN_MIN) &&
			(m_tdata[CHAN_LO +: CHAN_W] <= CHAN_MAX))
		else $error("MIDI channel out of range");

endmodule

bind euclidean_rhythm_trigger_top ert_checker u_ert_checker (.*);
